/* rtl/core/world_to_screen_projection_top_defines.svh */
// Assertion helpers used by the projection top module.
`ifndef WORLD_TO_SCREEN_PROJECTION_TOP_DEFINES_SVH
`define WORLD_TO_SCREEN_PROJECTION_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define WSP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define WSP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/wsp_pkg.sv */
`default_nettype none
package wsp_pkg;
    localparam int FRAC_BITS = 16;
    localparam int COEF_W    = 32;
    localparam int DIM_W     = 13;
    localparam int NEAR_W    = 31;
    localparam int OUT_W     = 30;
    localparam int PROD_W    = 2 * COEF_W;
    localparam int SUM_W     = PROD_W - FRAC_BITS + 2;
    localparam int R_W       = SUM_W + 1;
    localparam int A_W       = DIM_W + FRAC_BITS;
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;

    localparam logic [DIM_W-1:0]  WIDTH_RESET  = 13'd1920;
    localparam logic [DIM_W-1:0]  HEIGHT_RESET = 13'd1080;
    localparam logic [NEAR_W-1:0] NEAR_RESET   = NEAR_W'(((1 << FRAC_BITS) + 5) / 10);
    localparam logic [OUT_W-1:0]  MINUS_ONE    = OUT_W'(-(64'sd1 <<< FRAC_BITS));

    localparam logic MODE_LOAD    = 1'b0;
    localparam logic MODE_PROJECT = 1'b1;

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_NEAR   = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic             vis;
        logic [SUM_W-1:0] d;
        logic [SUM_W-1:0] nx;
        logic [SUM_W-1:0] ny;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
    } t_div_word;

    typedef struct packed {
        logic [R_W-1:0]   r;
        logic [OUT_W-1:0] q;
    } t_lane;

    // One bit of floor(a * n / d): double the remainder, then add n for a set bit.
    function automatic t_lane div_step(t_lane cur, logic [SUM_W-1:0] n,
                                       logic [SUM_W-1:0] d, logic abit);
        t_lane          nxt;
        logic [R_W-1:0] r2;
        logic [R_W-1:0] d_e;
        d_e   = {1'b0, d};
        nxt.q = {cur.q[OUT_W-2:0], 1'b0};
        r2    = {cur.r[R_W-2:0], 1'b0};
        if (r2 >= d_e) begin
            nxt.q = nxt.q + OUT_W'(1);
            r2    = r2 - d_e;
        end
        if (abit) begin
            r2 = r2 + {1'b0, n};
            if (r2 >= d_e) begin
                nxt.q = nxt.q + OUT_W'(1);
                r2    = r2 - d_e;
            end
        end
        nxt.r = r2;
        return nxt;
    endfunction
endpackage
`default_nettype wire

/* rtl/core/wsp_channels.sv */
`default_nettype none
interface wsp_in_if import wsp_pkg::*; ;
    logic                     valid;
    logic                     ready;
    logic                     mode;
    logic [3:0]               coef_index;
    logic signed [COEF_W-1:0] coef_value;
    logic signed [COEF_W-1:0] point_x;
    logic signed [COEF_W-1:0] point_y;
    logic signed [COEF_W-1:0] point_z;
    modport source (output valid, mode, coef_index, coef_value, point_x, point_y, point_z,
                    input ready);
    modport sink (input valid, mode, coef_index, coef_value, point_x, point_y, point_z,
                  output ready);
endinterface

interface wsp_out_if import wsp_pkg::*; ;
    logic                    valid;
    logic                    ready;
    logic                    on_screen;
    logic signed [OUT_W-1:0] screen_x;
    logic signed [OUT_W-1:0] screen_y;
    modport source (output valid, on_screen, screen_x, screen_y, input ready);
    modport sink (input valid, on_screen, screen_x, screen_y, output ready);
endinterface
`default_nettype wire

/* rtl/core/world_to_screen_projection_top.sv */
// Throughput: one word per cycle, loads and projects alike, unless the output stalls;
// loads give no result. Points and coefficients are Q16.16.
// Stages: 9 parallel 32x32 products, row sums, clip test, then one quotient bit
// per stage in two long-division lanes, then the output register.
// Reset (synchronous, active low) empties the pipe and restores the viewport registers;
// the view matrix has no reset and must be fully loaded before projecting.
`default_nettype none
`include "world_to_screen_projection_top_defines.svh"
module world_to_screen_projection_top import wsp_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    wsp_in_if.sink                 i_in,
    wsp_out_if.source              o_out,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready
);
    logic [DIM_W-1:0]  r_width;
    logic [DIM_W-1:0]  r_height;
    logic [NEAR_W-1:0] r_near;
    logic signed [COEF_W-1:0] r_mat [16];

    logic cfg_wr;
    logic in_acc;
    logic en1, en2, en3, en_out;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
            r_near   <= NEAR_RESET;
        end else if (cfg_wr) begin
            case (t_reg_idx'(paddr[3:2]))
                REG_WIDTH:  r_width  <= pwdata[DIM_W-1:0];
                REG_HEIGHT: r_height <= pwdata[DIM_W-1:0];
                REG_NEAR:   r_near   <= pwdata[NEAR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (t_reg_idx'(paddr[3:2]))
            REG_WIDTH:  prdata = DATA_W'(r_width);
            REG_HEIGHT: prdata = DATA_W'(r_height);
            REG_NEAR:   prdata = DATA_W'(r_near);
            default:    prdata = '0;
        endcase
    end

    // Take no word while in reset.
    assign i_in.ready = en1 && i_rst_n;
    assign in_acc     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (in_acc && i_in.mode == MODE_LOAD) begin
            r_mat[i_in.coef_index] <= i_in.coef_value;
        end
    end

    // Stage 1: products of rows 0, 1 and 3 with the point.
    logic                     r_v1;
    logic signed [PROD_W-1:0] r_p [3][3];
    logic signed [COEF_W-1:0] r_t [3];

    assign en1 = !r_v1 || en2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en1) begin
            r_v1 <= in_acc && i_in.mode == MODE_PROJECT;
        end
    end

    for (genvar rr = 0; rr < 3; rr++) begin : g_row
        localparam int MROW = (rr == 2) ? 3 : rr;
        always_ff @(posedge i_clk) begin
            if (en1) begin
                r_p[rr][0] <= PROD_W'(i_in.point_x) * PROD_W'(r_mat[MROW*4+0]);
                r_p[rr][1] <= PROD_W'(i_in.point_y) * PROD_W'(r_mat[MROW*4+1]);
                r_p[rr][2] <= PROD_W'(i_in.point_z) * PROD_W'(r_mat[MROW*4+2]);
                r_t[rr]    <= r_mat[MROW*4+3];
            end
        end
    end

    // Stage 2: floor-shift each product and sum the row.
    logic                    r_v2;
    logic signed [SUM_W-1:0] r_c [3];

    assign en2 = !r_v2 || en3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en2) begin
            r_v2 <= r_v1;
        end
    end

    for (genvar rr = 0; rr < 3; rr++) begin : g_sum
        always_ff @(posedge i_clk) begin
            if (en2) begin
                r_c[rr] <= SUM_W'(r_t[rr])
                         + SUM_W'(r_p[rr][0] >>> FRAC_BITS)
                         + SUM_W'(r_p[rr][1] >>> FRAC_BITS)
                         + SUM_W'(r_p[rr][2] >>> FRAC_BITS);
            end
        end
    end

    // Stage 3: clip test and divider operands.
    logic                    r_v3;
    t_div_word               r_dw;
    t_div_word               n_dw;
    logic signed [SUM_W-1:0] cx, cy, cw, near_s;
    logic                    in_x, in_y;
    logic                    div_ready;

    assign cx     = r_c[0];
    assign cy     = r_c[1];
    assign cw     = r_c[2];
    assign near_s = SUM_W'($signed({1'b0, r_near}));
    assign in_x   = (cx >= -cw) && (cx <= cw);
    assign in_y   = (cy >= -cw) && (cy <= cw);

    always_comb begin
        n_dw.vis = (cw > 0) && (cw >= near_s)
                 && (r_width == '0 || in_x) && (r_height == '0 || in_y);
        n_dw.d   = SUM_W'(cw) << 1;
        n_dw.nx  = (r_width != '0) ? SUM_W'(cw + cx) : '0;
        n_dw.ny  = (r_height != '0) ? SUM_W'(cw - cy) : '0;
        n_dw.w   = r_width;
        n_dw.h   = r_height;
    end

    assign en3 = !r_v3 || div_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_dw <= n_dw;
        end
    end

    logic             div_valid;
    t_div_word        div_word;
    logic [OUT_W-1:0] div_qx, div_qy;

    wsp_div_pipe u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v3),
        .o_ready (div_ready),
        .i_word  (r_dw),
        .o_valid (div_valid),
        .i_ready (en_out),
        .o_word  (div_word),
        .o_qx    (div_qx),
        .o_qy    (div_qy)
    );

    // Output register: hold the word until taken.
    logic             r_ov;
    logic             r_on;
    logic [OUT_W-1:0] r_sx, r_sy;

    assign en_out = !r_ov || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en_out) begin
            r_ov <= div_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out) begin
            r_on <= div_word.vis;
            r_sx <= div_word.vis ? div_qx : MINUS_ONE;
            r_sy <= div_word.vis ? div_qy : MINUS_ONE;
        end
    end

    assign o_out.valid     = r_ov;
    assign o_out.on_screen = r_on;
    assign o_out.screen_x  = $signed(r_sx);
    assign o_out.screen_y  = $signed(r_sy);

    `WSP_ASSERT_IMP(a_hidden_minus_one, r_ov && !r_on, r_sx == MINUS_ONE && r_sy == MINUS_ONE, "hidden point not at -1.0")
    `WSP_ASSERT_IMP(a_visible_nonneg, r_ov && r_on, !r_sx[OUT_W-1] && !r_sy[OUT_W-1], "visible point negative")
    `WSP_ASSERT_NXT(a_load_no_slot, in_acc && i_in.mode == MODE_LOAD, !r_v1, "load word entered the pipe")
endmodule
`default_nettype wire

/* rtl/core/wsp_div_pipe.sv */
`default_nettype none
module wsp_div_pipe import wsp_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire t_div_word  i_word,
    output logic            o_valid,
    input  wire logic       i_ready,
    output t_div_word       o_word,
    output logic [OUT_W-1:0] o_qx,
    output logic [OUT_W-1:0] o_qy
);
    // Index 0 is the pipe input, index j+1 the output of stage j.
    logic      c_v    [A_W+1];
    t_div_word c_word [A_W+1];
    t_lane     c_lx   [A_W+1];
    t_lane     c_ly   [A_W+1];
    logic      en     [A_W+1];

    assign c_v[0]    = i_valid;
    assign c_word[0] = i_word;
    assign c_lx[0]   = '0;
    assign c_ly[0]   = '0;
    assign en[A_W]   = i_ready;
    assign o_ready   = en[0];

    for (genvar j = 0; j < A_W; j++) begin : g_stage
        localparam int BIT = A_W - 1 - j;
        logic      abit;
        logic      r_v;
        t_div_word r_word;
        t_lane     r_lx;
        t_lane     r_ly;

        if (BIT >= FRAC_BITS) begin : g_wbit
            assign abit = c_word[j].w[BIT-FRAC_BITS];
        end else begin : g_zbit
            assign abit = 1'b0;
        end
        logic abit_h;
        if (BIT >= FRAC_BITS) begin : g_hbit
            assign abit_h = c_word[j].h[BIT-FRAC_BITS];
        end else begin : g_hzbit
            assign abit_h = 1'b0;
        end

        // Advance when this slot is free or moves on.
        assign en[j] = !r_v || en[j+1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (en[j]) begin
                r_v <= c_v[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en[j]) begin
                r_word <= c_word[j];
                r_lx   <= div_step(c_lx[j], c_word[j].nx, c_word[j].d, abit);
                r_ly   <= div_step(c_ly[j], c_word[j].ny, c_word[j].d, abit_h);
            end
        end

        assign c_v[j+1]    = r_v;
        assign c_word[j+1] = r_word;
        assign c_lx[j+1]   = r_lx;
        assign c_ly[j+1]   = r_ly;
    end

    assign o_valid = c_v[A_W];
    assign o_word  = c_word[A_W];
    assign o_qx    = c_lx[A_W].q;
    assign o_qy    = c_ly[A_W].q;
endmodule
`default_nettype wire

/* tb/wsp_tb_checker.sv */
`default_nettype none
module wsp_tb_checker import wsp_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    wsp_in_if.sink       i_in,
    wsp_out_if.sink      i_out,
    output int           o_fail_count,
    output int           o_pending
);
    typedef struct packed {
        logic             on_screen;
        logic [OUT_W-1:0] screen_x;
        logic [OUT_W-1:0] screen_y;
    } t_pixel;

    logic signed [COEF_W-1:0] matrix_copy [16];
    logic [DIM_W-1:0]         width_copy;
    logic [DIM_W-1:0]         height_copy;
    logic [NEAR_W-1:0]        near_copy;
    t_pixel                   pixel_queue [$];

    function automatic logic signed [63:0] row_sum(int row, logic signed [63:0] x,
                                                   logic signed [63:0] y,
                                                   logic signed [63:0] z);
        logic signed [63:0] acc;
        acc = 64'(matrix_copy[row*4+3]);
        acc = acc + ((x * 64'(matrix_copy[row*4+0])) >>> FRAC_BITS);
        acc = acc + ((y * 64'(matrix_copy[row*4+1])) >>> FRAC_BITS);
        acc = acc + ((z * 64'(matrix_copy[row*4+2])) >>> FRAC_BITS);
        return acc;
    endfunction

    function automatic t_pixel project_point(logic signed [31:0] px,
                                             logic signed [31:0] py,
                                             logic signed [31:0] pz);
        logic signed [63:0] cx, cy, cw;
        logic [127:0]       num, den;
        logic               vis;
        t_pixel             res;
        cx = row_sum(0, px, py, pz);
        cy = row_sum(1, px, py, pz);
        cw = row_sum(3, px, py, pz);
        vis = cw > 0 && cw >= $signed({33'd0, near_copy});
        if (vis && width_copy != 0 && (cx < -cw || cx > cw)) vis = 0;
        if (vis && height_copy != 0 && (cy < -cw || cy > cw)) vis = 0;
        if (!vis) begin
            res.on_screen = 0;
            res.screen_x  = MINUS_ONE;
            res.screen_y  = MINUS_ONE;
        end else begin
            den = 128'(2 * cw);
            num = (width_copy != 0) ? 128'(cw + cx) : 128'd0;
            res.screen_x = OUT_W'((128'(width_copy) << FRAC_BITS) * num / den);
            num = (height_copy != 0) ? 128'(cw - cy) : 128'd0;
            res.screen_y = OUT_W'((128'(height_copy) << FRAC_BITS) * num / den);
            res.on_screen = 1;
        end
        return res;
    endfunction

    // Register writes come from the top while the pipe is empty.
    task automatic mirror_reg(t_reg_idx idx, logic [31:0] value);
        case (idx)
            REG_WIDTH: begin
                width_copy = value[DIM_W-1:0];
            end
            REG_HEIGHT: begin
                height_copy = value[DIM_W-1:0];
            end
            REG_NEAR: begin
                near_copy = value[NEAR_W-1:0];
            end
            default: begin
            end
        endcase
    endtask

    initial begin
        width_copy   = WIDTH_RESET;
        height_copy  = HEIGHT_RESET;
        near_copy    = NEAR_RESET;
        o_fail_count = 0;
        o_pending    = 0;
        foreach (matrix_copy[i]) matrix_copy[i] = '0;
    end

    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n && i_in.valid && i_in.ready) begin
            if (i_in.mode == MODE_LOAD) begin
                matrix_copy[i_in.coef_index] = i_in.coef_value;
            end else begin
                pixel_queue.push_back(project_point(i_in.point_x, i_in.point_y,
                                                    i_in.point_z));
            end
        end
        if (i_rst_n && i_out.valid && i_out.ready) begin
            if (pixel_queue.size() == 0) begin
                $error("unexpected word on output");
                o_fail_count++;
            end else begin
                want = pixel_queue.pop_front();
                if (want.on_screen !== i_out.on_screen) begin
                    $error("on_screen: expected %0d, got %0d", want.on_screen,
                           i_out.on_screen);
                    o_fail_count++;
                end
                if (want.screen_x !== i_out.screen_x) begin
                    $error("screen_x: expected %0h, got %0h", want.screen_x,
                           i_out.screen_x);
                    o_fail_count++;
                end
                if (want.screen_y !== i_out.screen_y) begin
                    $error("screen_y: expected %0h, got %0h", want.screen_y,
                           i_out.screen_y);
                    o_fail_count++;
                end
            end
        end
        o_pending = pixel_queue.size();
    end
endmodule
`default_nettype wire

/* tb/world_to_screen_projection_top_tb.sv */
`default_nettype none
module world_to_screen_projection_top_tb;
    import wsp_pkg::*;

    localparam int LATENCY   = 40;
    localparam int MAX_CYCLE = 400000;

    logic              i_clk = 0;
    logic              i_rst_n = 0;
    logic              psel = 0, penable = 0, pwrite = 0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    int                fail_count, pending;
    int                cycle_count = 0;
    bit                sink_hold = 0;

    wsp_in_if  in_ch ();
    wsp_out_if out_ch ();

    world_to_screen_projection_top i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    wsp_tb_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .i_out(out_ch.sink),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always #4 i_clk = ~i_clk;

    initial begin
        in_ch.valid = 0; in_ch.mode = MODE_LOAD; in_ch.coef_index = '0;
        in_ch.coef_value = '0; in_ch.point_x = '0; in_ch.point_y = '0;
        in_ch.point_z = '0; out_ch.ready = 0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLE) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Output side: random stalls, or a long hold while the pipe fills.
    initial begin
        int gap;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (sink_hold) begin
                out_ch.ready <= 0;
                repeat (200) @(posedge i_clk);
                sink_hold = 0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
            if (gap > 0) begin
                out_ch.ready <= 0;
                repeat (gap) @(posedge i_clk);
            end
            out_ch.ready <= 1;
            @(posedge i_clk iff out_ch.valid);
        end
    end

    task automatic reg_write(t_reg_idx idx, logic [31:0] value);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= ADDR_W'(4 * int'(idx)); pwdata <= value;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk iff pready);
        psel <= 0; penable <= 0; pwrite <= 0;
        i_checker.mirror_reg(idx, value);
    endtask

    task automatic send_word(logic mode, logic [3:0] idx, logic [31:0] cv,
                             logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                             bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            in_ch.valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1; in_ch.mode <= mode; in_ch.coef_index <= idx;
        in_ch.coef_value <= cv; in_ch.point_x <= px; in_ch.point_y <= py;
        in_ch.point_z <= pz;
        @(posedge i_clk iff in_ch.ready);
    endtask

    task automatic load_coef(logic [3:0] idx, logic [31:0] cv);
        send_word(MODE_LOAD, idx, cv, $urandom, $urandom, $urandom, 0);
    endtask

    task automatic project(logic [31:0] px, logic [31:0] py, logic [31:0] pz, bit no_gap);
        send_word(MODE_PROJECT, 4'($urandom), $urandom, px, py, pz, no_gap);
    endtask

    // Modest perspective-like matrix so that many points land on screen.
    task automatic load_view();
        for (int i = 0; i < 16; i++) begin
            logic [31:0] cv;
            case ($urandom_range(0, 9))
                0: cv = $urandom;
                1: cv = '0;
                default: cv = (i % 5 == 0) ? 32'($urandom_range(16384, 131072))
                                           : 32'($signed($urandom_range(0, 65536)) - 32768);
            endcase
            if (i == 15) cv = 32'($urandom_range(65536, 8 * 65536));
            load_coef(i[3:0], cv);
        end
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 7))
            0: return $urandom;
            1: return 32'h8000_0000;
            2: return 32'h7FFF_FFFF;
            default: return 32'($signed($urandom_range(0, 20 * 65536)) - 10 * 65536);
        endcase
    endfunction

    task automatic drain();
        in_ch.valid <= 0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: load identity-like view with w = z, then extremes.
        for (int i = 0; i < 16; i++)
            load_coef(i[3:0], (i == 0 || i == 5 || i == 14) ? 32'h0001_0000 : 32'h0);
        project(32'h0, 32'h0, 32'h0001_0000, 0);
        project(32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000, 0);
        project(32'hFFFF_0000, 32'h0001_0000, 32'h0001_0000, 0);
        project(32'h0001_0001, 32'h0, 32'h0001_0000, 0);
        project(32'h0, 32'h0, 32'h0, 0);
        project(32'h0, 32'h0, 32'hFFFF_0000, 0);
        project(32'h0, 32'h0, 32'd6553, 0);
        project(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
        project(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0);
        project(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        load_coef(4'd15, 32'h8000_0000);
        project(32'h0, 32'h0, 32'h0, 0);
        load_coef(4'd15, 32'h7FFF_FFFF);
        project(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 0);
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    reg_write(REG_WIDTH, 32'd0); reg_write(REG_HEIGHT, 32'd4096);
                    reg_write(REG_NEAR, 32'd0);
                end
                1: begin
                    reg_write(REG_WIDTH, 32'd4096); reg_write(REG_HEIGHT, 32'd0);
                    reg_write(REG_NEAR, 32'h7FFF_FFFF);
                end
                2: begin
                    reg_write(REG_WIDTH, 32'h1FFF); reg_write(REG_HEIGHT, 32'h1FFF);
                    reg_write(REG_NEAR, 32'd1);
                end
                3: begin
                    reg_write(REG_WIDTH, 32'd1); reg_write(REG_HEIGHT, 32'd1);
                    reg_write(REG_NEAR, 32'd6554);
                end
                default: begin
                    reg_write(REG_WIDTH, $urandom); reg_write(REG_HEIGHT, $urandom);
                    reg_write(REG_NEAR, $urandom_range(0, 3) == 0 ? $urandom
                                                                 : $urandom_range(0, 65536));
                end
            endcase
            load_view();
            for (int n = 0; n < 250; n++) begin
                if (phase == 2 && n == 20) sink_hold = 1;
                if ($urandom_range(0, 30) == 0)
                    load_coef(4'($urandom), $urandom_range(0, 1) ? $urandom
                                        : 32'($signed($urandom_range(0, 131072)) - 65536));
                else
                    project(rand_coord(), rand_coord(), rand_coord(),
                            (phase == 2 && n < 100) || $urandom_range(0, 2) == 0);
            end
            drain();
        end
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
`default_nettype wire

/* sim.f */
+incdir+rtl/core
rtl/core/wsp_pkg.sv
rtl/core/wsp_channels.sv
rtl/core/wsp_div_pipe.sv
rtl/core/world_to_screen_projection_top.sv
tb/wsp_tb_checker.sv
tb/world_to_screen_projection_top_tb.sv
